/* src/thfd_pkg.sv */
// ---------------------------------------------------------------------------
// thfd_pkg
// shared types, codes and the byte-wide crc-8 update for the frame decoder
// ---------------------------------------------------------------------------
package thfd_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_FAMILY  = 2'd2
   } status_type;

   localparam logic       FUNC_ROM     = 1'b0;
   localparam logic       FUNC_SCRATCH = 1'b1;

   localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

   localparam logic [7:0] FAMILY_OLD   = 8'h10;
   localparam logic [7:0] FAMILY_NEW_A = 8'h28;
   localparam logic [7:0] FAMILY_NEW_B = 8'h22;

   localparam logic [7:0] PER_DEGREE_NOMINAL = 8'h10;
   localparam logic [15:0] OLD_FRAC_MASK     = 16'hFFF0;
   localparam logic [15:0] OLD_REMAIN_BIAS   = 16'd12;

   localparam logic [7:0] RES_MASK   = 8'h60;
   localparam logic [7:0] RES_9BIT   = 8'h00;
   localparam logic [7:0] RES_10BIT  = 8'h20;
   localparam logic [7:0] RES_11BIT  = 8'h40;

   localparam logic [3:0] IDX_ROM_FAMILY  = 4'd0;
   localparam logic [3:0] IDX_ROM_LAST    = 4'd7;
   localparam logic [3:0] IDX_SP_TEMP_LO  = 4'd0;
   localparam logic [3:0] IDX_SP_TEMP_HI  = 4'd1;
   localparam logic [3:0] IDX_SP_CONFIG   = 4'd4;
   localparam logic [3:0] IDX_SP_REMAIN   = 4'd6;
   localparam logic [3:0] IDX_SP_PER_DEG  = 4'd7;
   localparam logic [3:0] IDX_SP_LAST     = 4'd8;
   localparam logic [3:0] IDX_MAX         = 4'd15;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data_in);
      logic [7:0] crc;
      logic [7:0] data;
      logic       mix;
      crc  = crc_in;
      data = data_in;
      for (int i = 0; i < 8; i++) begin
         mix  = crc[0] ^ data[0];
         crc  = {1'b0, crc[7:1]};
         if (mix) begin
            crc = crc ^ CRC_POLY_REFL;
         end
         data = {1'b0, data[7:1]};
      end
      return crc;
   endfunction

endpackage

/* src/thermometer_frame_decoder_unit.sv */
// ---------------------------------------------------------------------------
// thermometer_frame_decoder_unit
// decodes rom identity and scratchpad frames read from a temperature sensor
// ---------------------------------------------------------------------------
// usage:
//   req_ channel carries one bus byte per item in req_tdata; req_tuser
//   tags it as rom or scratchpad and marks the first byte of a frame.
//   the byte goes into an input register, then one pass of logic runs the
//   crc-8, byte position and captures and loads the result register.
//   rom byte 7 and scratchpad byte 8 each give one item on rsp_; all
//   other bytes give none.
//   rsp_tvalid is registered: an end byte passes the input register and
//   then the result register; a stalled result keeps it in the input register.
//   throughput: one item per cycle, limited only by rsp_tready.
//   reset clears the crc, byte count, old-part flag and both stages;
//   captured bytes hold garbage until a frame writes them.
//   when the receiver stalls, the result holds and the input register
//   fills, then req_tready drops; no item is lost.
// ---------------------------------------------------------------------------
module thermometer_frame_decoder_unit
   import thfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [1:0]  req_tuser,   // func, first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], old_part, temperature[15:0], zero pad
   output logic        rsp_tuser    // frame_kind
);

   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic        in_first_ff;
   logic [7:0]  in_byte_ff;

   logic [7:0]  crc_ff, crc_in;
   logic [3:0]  count_ff, count_in;
   logic        old_ff, old_in;

   logic [7:0]  temp_low_ff, temp_high_ff, config_ff, remain_ff, per_deg_ff, family_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   status_type  out_status_ff;
   logic        out_old_ff;
   logic [15:0] out_temp_ff;

   logic        advance;
   logic        take;
   logic [3:0]  idx;
   logic [7:0]  crc_base;
   logic [7:0]  crc_next;
   logic        rom_end, sp_end;
   status_type  status_val;
   logic [15:0] raw;
   logic [15:0] temp_val;

   assign advance    = !out_valid_ff || rsp_tready;
   assign take       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign idx      = in_first_ff ? 4'd0 : count_ff;
   assign crc_base = in_first_ff ? 8'd0 : crc_ff;
   assign crc_next = crc8_byte(crc_base, in_byte_ff);
   assign rom_end  = (in_func_ff == FUNC_ROM) && (idx == IDX_ROM_LAST);
   assign sp_end   = (in_func_ff == FUNC_SCRATCH) && (idx == IDX_SP_LAST);

   always_comb begin
      old_in     = old_ff;
      status_val = STATUS_OK;
      if (crc_next != 8'd0) begin
         status_val = STATUS_CRC_ERR;
      end else if (rom_end) begin
         priority if (family_ff == FAMILY_OLD) begin
            old_in = 1'b1;
         end else if (family_ff == FAMILY_NEW_A || family_ff == FAMILY_NEW_B) begin
            old_in = 1'b0;
         end else begin
            status_val = STATUS_FAMILY;
         end
      end
      if (!take || !rom_end) begin
         old_in = old_ff;
      end
   end

   always_comb begin
      raw = {temp_high_ff, temp_low_ff};
      if (old_ff) begin
         temp_val = {raw[12:0], 3'b000};
         if (per_deg_ff == PER_DEGREE_NOMINAL) begin
            temp_val = (temp_val & OLD_FRAC_MASK) + OLD_REMAIN_BIAS - {8'd0, remain_ff};
         end
      end else begin
         unique case (config_ff & RES_MASK)
            RES_9BIT:  temp_val = raw & 16'hFFF8;
            RES_10BIT: temp_val = raw & 16'hFFFC;
            RES_11BIT: temp_val = raw & 16'hFFFE;
            default:   temp_val = raw;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
      crc_in   = take ? crc_next : crc_ff;
      count_in = count_ff;
      if (take) begin
         count_in = (idx == IDX_MAX) ? IDX_MAX : idx + 4'd1;
      end
      out_valid_in = out_valid_ff;
      if (take && (rom_end || sp_end)) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         crc_ff       <= 8'd0;
         count_ff     <= 4'd0;
         old_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         old_ff       <= old_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_func_ff  <= req_tuser[0];
         in_first_ff <= req_tuser[1];
      end
      if (take) begin
         if (in_func_ff == FUNC_ROM) begin
            if (idx == IDX_ROM_FAMILY) begin
               family_ff <= in_byte_ff;
            end
         end else begin
            if (idx == IDX_SP_TEMP_LO) begin
               temp_low_ff <= in_byte_ff;
            end
            if (idx == IDX_SP_TEMP_HI) begin
               temp_high_ff <= in_byte_ff;
            end
            if (idx == IDX_SP_CONFIG) begin
               config_ff <= in_byte_ff;
            end
            if (idx == IDX_SP_REMAIN) begin
               remain_ff <= in_byte_ff;
            end
            if (idx == IDX_SP_PER_DEG) begin
               per_deg_ff <= in_byte_ff;
            end
         end
         if (rom_end || sp_end) begin
            out_kind_ff   <= in_func_ff;
            out_status_ff <= status_val;
            out_old_ff    <= old_in;
            out_temp_ff   <= sp_end ? temp_val : 16'd0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {5'd0, out_temp_ff, out_old_ff, out_status_ff};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for thermometer_frame_decoder_unit: a directed start,
// random well-formed and broken rom and scratchpad frames under several
// idle and stall mixes, and a long receiver hold-off
// ---------------------------------------------------------------------------
module testbench
   import thfd_pkg::*;
();

   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 150;

   typedef struct {
      logic              kind;
      status_type        status;
      logic              old_part;
      logic signed [15:0] temperature;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic [1:0]  req_tuser = 2'b00;   // func, first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // status[1:0], old_part, temperature[15:0], zero pad
   logic        rsp_tuser;          // frame_kind

   // decoder state mirrored on the bench side
   logic [7:0] crc_state = 8'h00;
   logic [3:0] pos_count = 4'd0;
   logic [7:0] temp_lo_byte, temp_hi_byte, cfg_byte, remain_byte, per_deg_byte;
   logic [7:0] family_id;
   logic       old_flag = 1'b0;

   reading_type awaited_readings[$];
   logic [7:0]  frame_buf[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int error_count = 0;
   int cycle_count = 0;

   event hold_go;
   logic hold_active = 1'b0;

   thermometer_frame_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ b[i];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ 8'h8C;
         end
      end
      return acc;
   endfunction

   function automatic void decode_sensor_byte(input logic fn, input logic first,
                                              input logic [7:0] b);
      logic [3:0]  pos;
      logic [15:0] raw;
      reading_type r;
      if (first) begin
         pos_count = 4'd0;
         crc_state = 8'h00;
      end
      pos = pos_count;
      crc_state = crc8_step(crc_state, b);
      if (fn == FUNC_ROM) begin
         if (pos == IDX_ROM_FAMILY) begin
            family_id = b;
         end
         if (pos == IDX_ROM_LAST) begin
            if (crc_state != 8'h00) begin
               r.status = STATUS_CRC_ERR;
            end else if (family_id == FAMILY_OLD) begin
               old_flag = 1'b1;
               r.status = STATUS_OK;
            end else if (family_id == FAMILY_NEW_A || family_id == FAMILY_NEW_B) begin
               old_flag = 1'b0;
               r.status = STATUS_OK;
            end else begin
               r.status = STATUS_FAMILY;
            end
            r.kind        = FUNC_ROM;
            r.old_part    = old_flag;
            r.temperature = 16'sd0;
            awaited_readings.push_back(r);
         end
      end else begin
         case (pos)
            IDX_SP_TEMP_LO: temp_lo_byte = b;
            IDX_SP_TEMP_HI: temp_hi_byte = b;
            IDX_SP_CONFIG:  cfg_byte     = b;
            IDX_SP_REMAIN:  remain_byte  = b;
            IDX_SP_PER_DEG: per_deg_byte = b;
            default: ;
         endcase
         if (pos == IDX_SP_LAST) begin
            raw = {temp_hi_byte, temp_lo_byte};
            if (old_flag) begin
               raw = raw << 3;
               if (per_deg_byte == PER_DEGREE_NOMINAL) begin
                  raw = (raw & OLD_FRAC_MASK) + OLD_REMAIN_BIAS - {8'h00, remain_byte};
               end
            end else begin
               case (cfg_byte & RES_MASK)
                  RES_9BIT:  raw = raw & 16'hFFF8;
                  RES_10BIT: raw = raw & 16'hFFFC;
                  RES_11BIT: raw = raw & 16'hFFFE;
                  default: ;
               endcase
            end
            r.kind        = FUNC_SCRATCH;
            r.status      = (crc_state != 8'h00) ? STATUS_CRC_ERR : STATUS_OK;
            r.old_part    = old_flag;
            r.temperature = raw;
            awaited_readings.push_back(r);
         end
      end
      if (pos_count != IDX_MAX) begin
         pos_count = pos_count + 4'd1;
      end
   endfunction

   task automatic send_byte(input logic fn, input logic first, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {first, fn};
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_sensor_byte(fn, first, b);
      items_sent++;
   endtask

   // sends frame_buf; the byte at flip_pos carries the other tag
   task automatic send_frame_buf(input logic fn, input logic mark, input int flip_pos);
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_byte((i == flip_pos) ? ~fn : fn, mark && (i == 0), frame_buf[i]);
      end
   endtask

   task automatic append_check_byte();
      logic [7:0] crc;
      crc = 8'h00;
      foreach (frame_buf[i]) begin
         crc = crc8_step(crc, frame_buf[i]);
      end
      frame_buf.push_back(crc);
   endtask

   task automatic send_random_frame();
      logic fn;
      int   body_len, pick, flip_pos;
      logic mark;
      fn = 1'($urandom_range(1));
      body_len = (fn == FUNC_ROM) ? 7 : 8;
      frame_buf.delete();
      for (int i = 0; i < body_len; i++) begin
         frame_buf.push_back(8'($urandom_range(255)));
      end
      if (fn == FUNC_ROM) begin
         pick = $urandom_range(3);
         if (pick == 0) frame_buf[0] = FAMILY_OLD;
         else if (pick == 1) frame_buf[0] = FAMILY_NEW_A;
         else if (pick == 2) frame_buf[0] = FAMILY_NEW_B;
      end else if ($urandom_range(1)) begin
         frame_buf[IDX_SP_PER_DEG] = PER_DEGREE_NOMINAL;
      end
      append_check_byte();
      flip_pos = -1;
      pick = $urandom_range(99);
      if (pick < 12) begin
         frame_buf[$urandom_range(body_len)] ^= 8'h01 << $urandom_range(7);
      end else if (pick < 18) begin
         repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 24) begin
         while (frame_buf.size() > $urandom_range(1, body_len)) void'(frame_buf.pop_back());
      end else if (pick < 30) begin
         flip_pos = $urandom_range(body_len);
      end
      mark = ($urandom_range(19) != 0);
      send_frame_buf(fn, mark, flip_pos);
   endtask

   task automatic test_directed_frames();
      // scratchpad first with no start mark, full resolution, most negative reading
      frame_buf = '{8'h00, 8'h80, 8'h5A, 8'hA5, 8'h60, 8'hC3, 8'hFF, 8'h10};
      append_check_byte();
      send_frame_buf(FUNC_SCRATCH, 1'b0, -1);
      // old family identity, one byte tagged as scratchpad
      frame_buf = '{FAMILY_OLD, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hAA, 8'h55};
      append_check_byte();
      send_frame_buf(FUNC_ROM, 1'b1, 3);
      // old part, max raw, bad check byte, then bytes past the end
      frame_buf = '{8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h1F, 8'hFF, 8'h00, PER_DEGREE_NOMINAL};
      append_check_byte();
      frame_buf[8] ^= 8'h01;
      frame_buf.push_back(8'hFF);
      frame_buf.push_back(8'h00);
      send_frame_buf(FUNC_SCRATCH, 1'b1, -1);
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(1'($urandom_range(1)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
            end
         end else begin
            send_random_frame();
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      -> hold_go;
      repeat (5) send_random_frame();
   endtask

   // receiver hold-off, counted in cycles
   always begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      reading_type r;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (awaited_readings.size() == 0) begin
            $error("unexpected item: tuser %b tdata %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            r = awaited_readings.pop_front();
            if (rsp_tuser !== r.kind) begin
               $error("frame_kind expected %0d actual %0d", r.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[1:0] !== r.status) begin
               $error("status expected %0d actual %0d", r.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[2] !== r.old_part) begin
               $error("old_part expected %0d actual %0d", r.old_part, rsp_tdata[2]);
               error_count++;
            end
            if (rsp_tdata[18:3] !== r.temperature) begin
               $error("temperature expected %0d actual %0d",
                      r.temperature, $signed(rsp_tdata[18:3]));
               error_count++;
            end
         end
      end
      rsp_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_random_frames(0, 0, 170);
      test_random_frames(53, 0, 170);
      test_backpressure();
      test_random_frames(0, 53, 170);
      test_random_frames(20, 20, 170);
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/thfd_pkg.sv
src/thermometer_frame_decoder_unit.sv
verif/testbench.sv
